[rtl/itoa_pkg.sv]
// shared constants, types and a helper function for the integer to ascii converter
package itoa_pkg;

    localparam int VALUE_BITS = 32;
    localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int HEX_BITS   = HEX_DIGITS * 4;
    localparam int DIG_BITS   = DEC_DIGITS * 4;
    localparam int CNT_W      = $clog2(DEC_DIGITS + 1);
    localparam int BIT_W      = $clog2(VALUE_BITS + 1);
    localparam int IN_BITS    = 32;
    localparam int CHAR_BITS  = 7;

    localparam logic [1:0] CMD_SIGNED   = 2'd0;
    localparam logic [1:0] CMD_UNSIGNED = 2'd1;
    localparam logic [1:0] CMD_HEX      = 2'd2;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2d;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic hex;
        logic neg;
        logic bit_last;
        logic top_zero;
        logic one_left;
        logic out_free;
    } status_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + CHAR_BITS'(d);
        end
        else
        begin
            c = CHAR_A + CHAR_BITS'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

[rtl/itoa_ctrl.sv]
// sequencer for load, binary to bcd conversion, leading zero skip and character output
module itoa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  itoa_pkg::status_t status,
    output itoa_pkg::cmd_t    cmd
);
    import itoa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = status.hex ? ST_SKIP : ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (status.bit_last)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (!(status.top_zero && !status.one_left))
                begin
                    state_next = status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free && status.one_left)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
            end
            ST_SKIP:
            begin
                cmd.skip = status.top_zero && !status.one_left;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = status.out_free;
            end
            ST_EMIT:
            begin
                cmd.emit_digit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/itoa_datapath.sv]
// magnitude and digit registers, shift-add-3 conversion and output register
module itoa_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [1:0]                         command,
    input  logic [itoa_pkg::IN_BITS-1:0]       value,
    input  itoa_pkg::cmd_t                     cmd,
    output itoa_pkg::status_t                  status,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [itoa_pkg::CHAR_BITS-1:0]     out_char,
    output logic                               out_last
);
    import itoa_pkg::*;

    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    logic [DIG_BITS-1:0]   dig_reg;
    logic [DIG_BITS-1:0]   dig_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [BIT_W-1:0]      bits_reg;
    logic [BIT_W-1:0]      bits_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic [CHAR_BITS-1:0]  char_reg;
    logic [CHAR_BITS-1:0]  char_next;
    logic                  last_reg;
    logic                  last_next;

    logic [63:0]           wide_in;
    logic [VALUE_BITS-1:0] word;
    logic                  in_neg;
    logic                  in_hex;
    logic [VALUE_BITS-1:0] mag;
    logic [HEX_BITS-1:0]   mag_hex;
    logic [DIG_BITS-1:0]   hex_load;
    logic [DIG_BITS-1:0]   adj;
    logic [3:0]            top_nib;

    assign wide_in = 64'(value);
    assign word    = wide_in[VALUE_BITS-1:0];
    assign in_hex  = (command == CMD_HEX);
    assign in_neg  = (command == CMD_SIGNED) && word[VALUE_BITS-1];
    assign mag     = in_neg ? (~word + VALUE_BITS'(1)) : word;
    assign mag_hex = HEX_BITS'(mag);
    assign top_nib = dig_reg[DIG_BITS-1 -: 4];

    always_comb
    begin
        hex_load = '0;
        hex_load[DIG_BITS-1 -: HEX_BITS] = mag_hex;
    end

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb
    begin
        adj = dig_reg;
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (dig_reg[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = dig_reg[i*4 +: 4] + 4'd3;
            end
        end
    end

    assign status.hex      = in_hex;
    assign status.neg      = neg_reg;
    assign status.bit_last = (bits_reg == BIT_W'(1));
    assign status.top_zero = (top_nib == 4'd0);
    assign status.one_left = (cnt_reg == CNT_W'(1));
    assign status.out_free = !valid_reg || out_ready;

    always_comb
    begin
        bin_next   = bin_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        neg_next   = neg_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !out_ready;
        if (cmd.load)
        begin
            bin_next  = mag;
            neg_next  = in_neg;
            bits_next = BIT_W'(VALUE_BITS);
            dig_next  = in_hex ? hex_load : '0;
            cnt_next  = in_hex ? CNT_W'(HEX_DIGITS) : CNT_W'(DEC_DIGITS);
        end
        if (cmd.conv_step)
        begin
            dig_next  = {adj[DIG_BITS-2:0], bin_reg[VALUE_BITS-1]};
            bin_next  = bin_reg << 1;
            bits_next = bits_reg - BIT_W'(1);
        end
        if (cmd.skip || cmd.emit_digit)
        begin
            dig_next = dig_reg << 4;
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (cmd.emit_digit)
        begin
            char_next  = digit_char(top_nib);
            last_next  = status.one_left;
            valid_next = 1'b1;
        end
        if (cmd.emit_sign)
        begin
            char_next  = CHAR_MINUS;
            last_next  = 1'b0;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            bits_reg  <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            bits_reg  <= bits_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

[rtl/integer_to_ascii_digits_core.sv]
// top level of the integer to ascii converter: signed, unsigned decimal or hex text
//
//  group   dir   tdata bits              tuser / tlast
//  s_*     in    [31:0] value            tuser[1:0] command
//  m_*     out   [6:0] text_char, [7] 0  tlast = last
//
// a beat is taken, then shift-add-3 conversion runs over all VALUE_BITS bits for
// decimal (none for hex), leading zero digits are skipped one per cycle, and the
// characters go out one per cycle while the output is not stalled, with a minus sign
// first for a negative signed word
// reset clears the sequencer and the output valid flag
// a stalled output holds the sequencer; the next input beat is taken while the
// final character still waits in the output register
module integer_to_ascii_digits_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] text_char, [7] zero
    output logic        m_tlast
);
    import itoa_pkg::*;

    cmd_t                 cmd;
    status_t              status;
    logic [CHAR_BITS-1:0] out_char;

    itoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    itoa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (s_tuser),
        .value     (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

endmodule

[tb/tb_integer_to_ascii_digits_core.sv]
// self-checking testbench for integer_to_ascii_digits_core: directed table, then random words
module tb_integer_to_ascii_digits_core;
    timeunit 1ns;
    timeprecision 1ps;

    import itoa_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_WORDS = 460;
    localparam int DIR_ROWS     = 23;
    localparam int TAIL_CYCLES  = 64;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } text_beat_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value
    logic [1:0]  s_tuser  = '0;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [6:0] text_char, [7] zero
    logic        m_tlast;

    text_beat_t  text_q[$];
    int          error_count  = 0;
    int          words_sent   = 0;
    int          chars_seen   = 0;
    int          cycle_count  = 0;
    bit          tx_no_gaps   = 1'b0;
    bit          rx_no_stalls = 1'b0;

    // directed rows: an empty string means the expected text comes from the predictor
    logic [1:0]  dir_cmd [DIR_ROWS] = '{
        CMD_SIGNED, CMD_UNSIGNED, CMD_HEX, CMD_SIGNED, CMD_SIGNED, CMD_SIGNED,
        CMD_SIGNED, CMD_UNSIGNED, CMD_UNSIGNED, CMD_HEX, CMD_HEX, CMD_HEX,
        CMD_HEX, CMD_HEX, CMD_SPARE, CMD_SPARE, CMD_UNSIGNED, CMD_UNSIGNED,
        CMD_SIGNED, CMD_SIGNED, CMD_UNSIGNED, CMD_HEX, CMD_SIGNED
    };
    logic [31:0] dir_val [DIR_ROWS] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
        32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff,
        32'h8000_0000, 32'hdead_beef, 32'h0000_000a, 32'h0123_abcd, 32'hffff_ffff,
        32'h0000_0000, 32'h0000_0009, 32'h0000_000a, 32'h3b9a_ca00, 32'hc465_3600,
        32'h1234_5678, 32'h0000_0010, 32'hffff_fff6
    };
    string       dir_text [DIR_ROWS] = '{
        "0", "0", "0", "1", "-1",
        "-2147483648", "2147483647", "4294967295", "2147483648", "ffffffff",
        "80000000", "deadbeef", "a", "", "4294967295",
        "0", "9", "10", "1000000000", "",
        "", "10", "-10"
    };

    integer_to_ascii_digits_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d characters outstanding", $time, text_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void predict_text(input logic [1:0] cmd, input logic [31:0] val);
        logic [31:0]          mag;
        logic [31:0]          radix;
        logic [31:0]          dig;
        logic                 neg;
        logic [CHAR_BITS-1:0] digs[$];
        neg   = (cmd == CMD_SIGNED) && val[31];
        mag   = neg ? (32'd0 - val) : val;
        radix = (cmd == CMD_HEX) ? 32'd16 : 32'd10;
        do
        begin
            dig = mag % radix;
            if (dig < 10)
                digs.push_front(CHAR_ZERO + CHAR_BITS'(dig));
            else
                digs.push_front(CHAR_A + CHAR_BITS'(dig - 10));
            mag = mag / radix;
        end
        while (mag != 0);
        if (neg)
            text_q.push_back('{ch: CHAR_MINUS, last: 1'b0});
        foreach (digs[i])
            text_q.push_back('{ch: digs[i], last: (i == digs.size() - 1)});
    endfunction

    function automatic void queue_typed_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back('{ch: CHAR_BITS'(s[i]), last: (i == s.len() - 1)});
    endfunction

    // called at a rising edge; leaves the word on the bus until it is taken
    task automatic send_word(input logic [1:0] cmd, input logic [31:0] val, input string typed);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        if (typed.len() > 0)
            queue_typed_text(typed);
        else
            predict_text(cmd, val);
        words_sent++;
        if (words_sent % 32 == 0)
            tx_no_gaps = ($urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        logic [1:0]  cmd;
        logic [31:0] val;
        int          pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_word(dir_cmd[r], dir_val[r], dir_text[r]);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(0, 15);
            cmd  = (pick == 15) ? CMD_SPARE : 2'(pick % 3);
            case ($urandom_range(0, 5))
                0, 1: val = $urandom;
                2:    val = $urandom_range(0, 99);
                3:    val = $urandom >> $urandom_range(0, 31);
                4:    val = ~32'($urandom_range(0, 99));
                default:
                begin
                    // powers of ten and their neighbors
                    val = 32'd1;
                    repeat ($urandom_range(0, 9)) val = val * 10;
                    val = val + 32'($urandom_range(0, 2)) - 32'd1;
                end
            endcase
            send_word(cmd, val, "");
        end
        s_tvalid <= 1'b0;

        while (text_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("converted %0d words (%0d directed, %0d random) in all formats",
                 words_sent, DIR_ROWS, RANDOM_WORDS);
        $display("checked %0d characters, %0d mismatches", chars_seen, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int         stall;
        text_beat_t want;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = rx_no_stalls ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            chars_seen++;
            if (chars_seen % 40 == 0)
                rx_no_stalls = ($urandom_range(0, 3) == 0);
            if (text_q.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none actual %h last %b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                want = text_q.pop_front();
                if (m_tdata !== {1'b0, want.ch})
                begin
                    $display("%0t: text_char mismatch: expected %h actual %h",
                             $time, {1'b0, want.ch}, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last mismatch: expected %b actual %b",
                             $time, want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

endmodule
